// ----- rtl/sfhb_pkg.sv -----
// ----------------------------------------------------------------------------
// sfhb_pkg
// Shared types and constants of the SYN flood heavy-hitter blocker.
// ----------------------------------------------------------------------------
package sfhb_pkg;

  // Default table sizes
  localparam int unsigned SourceEntriesDef  = 64;
  localparam int unsigned BlockedEntriesDef = 64;

  // Field widths
  localparam int unsigned CntW  = 24;
  localparam int unsigned AddrW = 32;
  localparam int unsigned AccW  = 32;

  // Stream word widths
  localparam int unsigned InDataW  = 40;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 96;
  localparam int unsigned OutUserW = 3;

  // Item kinds
  localparam logic [1:0] FuncPacket  = 2'd0;
  localparam logic [1:0] FuncTick    = 2'd1;
  localparam logic [1:0] FuncPreload = 2'd2;

  // Event codes
  localparam logic [2:0] EvQuiet    = 3'd0;
  localparam logic [2:0] EvWarning  = 3'd1;
  localparam logic [2:0] EvScanDet  = 3'd2;
  localparam logic [2:0] EvScanOver = 3'd3;
  localparam logic [2:0] EvScanCont = 3'd4;

  // Register indexes
  localparam logic [1:0] RegWarn  = 2'd0;
  localparam logic [1:0] RegPanic = 2'd1;
  localparam logic [1:0] RegMin   = 2'd2;

  // Register reset values
  localparam logic [CntW-1:0] WarnRst  = 24'd50;
  localparam logic [CntW-1:0] PanicRst = 24'd100;
  localparam logic [CntW-1:0] MinRst   = 24'd10;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_BRD, ST_BCMP, ST_SRD, ST_SCMP,
    ST_TEVAL, ST_TRD, ST_TLATCH, ST_TFIN, ST_TOUT
  } state_e;

  typedef enum logic [1:0] {
    PUR_PACKET, PUR_PRELOAD, PUR_TICK
  } purpose_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic inc_syn;
    logic bidx_clr;
    logic bidx_inc;
    logic sidx_clr;
    logic sidx_inc;
    logic src_new;
    logic src_inc;
    logic blk_pre;
    logic key_tick;
    logic tick_eval;
    logic latch_cur;
    logic cand_update;
    logic tick_fin;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       is_syn;
    logic       bidx_end;
    logic       blk_hit;
    logic       sidx_end;
    logic       src_hit;
    logic       choose;
    logic       out_free;
  } sts_t;

endpackage

// ----- rtl/sfhb_ram.sv -----
// ----------------------------------------------------------------------------
// sfhb_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module sfhb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sfhb_ctrl.sv -----
// ----------------------------------------------------------------------------
// sfhb_ctrl
// Sequencer: dispatches items and walks the source and blocked tables.
// ----------------------------------------------------------------------------
module sfhb_ctrl
  import sfhb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e   state_q, state_d;
  purpose_e pur_q, pur_d;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pur_q   <= PUR_PACKET;
    end else begin
      state_q <= state_d;
      pur_q   <= pur_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    pur_d      = pur_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    cmd_o.key_tick = (pur_q == PUR_TICK);
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd_o.bidx_clr = 1'b1;
        case (sts_i.func)
          FuncPacket: begin
            if (sts_i.is_syn) begin
              cmd_o.inc_syn = 1'b1;
              pur_d   = PUR_PACKET;
              state_d = ST_BRD;
            end else begin
              state_d = ST_IDLE;
            end
          end
          FuncPreload: begin
            pur_d   = PUR_PRELOAD;
            state_d = ST_BRD;
          end
          FuncTick: state_d = ST_TEVAL;
          default:  state_d = ST_IDLE;
        endcase
      end
      // blocked table walk, end of list means not blocked
      ST_BRD: begin
        if (sts_i.bidx_end) begin
          case (pur_q)
            PUR_PACKET: begin
              cmd_o.sidx_clr = 1'b1;
              state_d = ST_SRD;
            end
            PUR_PRELOAD: begin
              cmd_o.blk_pre = 1'b1;
              state_d = ST_IDLE;
            end
            default: begin
              cmd_o.cand_update = 1'b1;
              cmd_o.sidx_inc    = 1'b1;
              state_d = ST_TRD;
            end
          endcase
        end else begin
          state_d = ST_BCMP;
        end
      end
      ST_BCMP: begin
        if (sts_i.blk_hit) begin
          if (pur_q == PUR_TICK) begin
            cmd_o.sidx_inc = 1'b1;
            state_d = ST_TRD;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          cmd_o.bidx_inc = 1'b1;
          state_d = ST_BRD;
        end
      end
      // source table walk for a packet
      ST_SRD: begin
        if (sts_i.sidx_end) begin
          cmd_o.src_new = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SCMP;
        end
      end
      ST_SCMP: begin
        if (sts_i.src_hit) begin
          cmd_o.src_inc = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.sidx_inc = 1'b1;
          state_d = ST_SRD;
        end
      end
      // interval tick
      ST_TEVAL: begin
        cmd_o.tick_eval = 1'b1;
        cmd_o.sidx_clr  = 1'b1;
        pur_d   = PUR_TICK;
        state_d = ST_TRD;
      end
      ST_TRD: begin
        if (!sts_i.choose) begin
          state_d = ST_TOUT;
        end else if (sts_i.sidx_end) begin
          state_d = ST_TFIN;
        end else begin
          state_d = ST_TLATCH;
        end
      end
      ST_TLATCH: begin
        cmd_o.latch_cur = 1'b1;
        cmd_o.bidx_clr  = 1'b1;
        state_d = ST_BRD;
      end
      ST_TFIN: begin
        cmd_o.tick_fin = 1'b1;
        state_d = ST_TOUT;
      end
      ST_TOUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/sfhb_dp.sv -----
// ----------------------------------------------------------------------------
// sfhb_dp
// Datapath: item capture, counters, tables, selection and result register.
// ----------------------------------------------------------------------------
module sfhb_dp
  import sfhb_pkg::*;
#(
  parameter int unsigned SOURCE_ENTRIES  = SourceEntriesDef,
  parameter int unsigned BLOCKED_ENTRIES = BlockedEntriesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [CntW-1:0]     warn_i,
  input  logic [CntW-1:0]     panic_i,
  input  logic [CntW-1:0]     min_i,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic [InUserW-1:0]  in_user_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o,
  output logic [OutUserW-1:0] out_user_o
);

  localparam int unsigned SIW = (SOURCE_ENTRIES > 1) ? $clog2(SOURCE_ENTRIES) : 1;
  localparam int unsigned SCW = $clog2(SOURCE_ENTRIES + 1);
  localparam int unsigned BIW = (BLOCKED_ENTRIES > 1) ? $clog2(BLOCKED_ENTRIES) : 1;
  localparam int unsigned BCW = $clog2(BLOCKED_ENTRIES + 1);
  localparam int unsigned SrcW = CntW + AddrW;
  localparam logic [CntW-1:0] CntMax = '1;

  // Captured item
  logic [1:0]       func_q;
  logic [AddrW-1:0] addr_q;
  logic             syn_q, ack_q;

  // Interval and scan state
  logic [SCW-1:0]  sidx_q, src_used_q;
  logic [BCW-1:0]  bidx_q, blk_used_q;
  logic [CntW-1:0] syn_cnt_q;
  logic            scan_q, ovf_q;
  logic [AccW-1:0] acc_q;

  // Selection
  logic [AddrW-1:0] cur_addr_q, best_addr_q;
  logic [CntW-1:0]  cur_cnt_q, best_cnt_q;
  logic             found_q, choose_q;

  // Result fields
  logic [2:0]       ev_q;
  logic [AccW-1:0]  total_q;
  logic             bvalid_q;
  logic [AddrW-1:0] baddr_q;

  // Output register
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic [OutUserW-1:0] out_user_q;

  // RAM ports
  logic            src_we, blk_we;
  logic [SrcW-1:0] src_wdata, src_rdata;
  logic [AddrW-1:0] blk_wdata, blk_rdata;
  logic [CntW-1:0] src_cnt_rd, src_cnt_inc;
  logic [AddrW-1:0] src_addr_rd, key;
  logic            src_full, blk_room, block_now;
  logic [AccW:0]   acc_sum;
  logic [AccW-1:0] acc_sat;

  assign src_cnt_rd  = src_rdata[SrcW-1:AddrW];
  assign src_addr_rd = src_rdata[AddrW-1:0];
  assign src_cnt_inc = (src_cnt_rd == CntMax) ? src_cnt_rd : src_cnt_rd + 1'b1;
  assign src_full    = (src_used_q >= SCW'(SOURCE_ENTRIES));
  assign blk_room    = (blk_used_q <  BCW'(BLOCKED_ENTRIES));
  assign block_now   = found_q && (best_cnt_q >= min_i);
  assign key         = cmd_i.key_tick ? cur_addr_q : addr_q;
  assign acc_sum     = {1'b0, acc_q} + {{(AccW + 1 - CntW){1'b0}}, syn_cnt_q};
  assign acc_sat     = acc_sum[AccW] ? '1 : acc_sum[AccW-1:0];

  // Table writes
  assign src_we    = (cmd_i.src_new && !src_full) || cmd_i.src_inc;
  assign src_wdata = cmd_i.src_inc ? {src_cnt_inc, addr_q} : {CntW'(1), addr_q};
  assign blk_we    = blk_room && (cmd_i.blk_pre || (cmd_i.tick_fin && block_now));
  assign blk_wdata = cmd_i.blk_pre ? addr_q : best_addr_q;

  sfhb_ram #(.WIDTH(SrcW), .DEPTH(SOURCE_ENTRIES)) u_src_ram (
    .clk_i   (clk_i),
    .we_i    (src_we),
    .waddr_i (sidx_q[SIW-1:0]),
    .wdata_i (src_wdata),
    .raddr_i (sidx_q[SIW-1:0]),
    .rdata_o (src_rdata)
  );

  sfhb_ram #(.WIDTH(AddrW), .DEPTH(BLOCKED_ENTRIES)) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (blk_we),
    .waddr_i (blk_used_q[BIW-1:0]),
    .wdata_i (blk_wdata),
    .raddr_i (bidx_q[BIW-1:0]),
    .rdata_o (blk_rdata)
  );

  // Status
  assign sts_o.func     = func_q;
  assign sts_o.is_syn   = syn_q && !ack_q;
  assign sts_o.bidx_end = (bidx_q >= blk_used_q);
  assign sts_o.blk_hit  = (blk_rdata == key);
  assign sts_o.sidx_end = (sidx_q >= src_used_q);
  assign sts_o.src_hit  = (src_addr_rd == addr_q);
  assign sts_o.choose   = choose_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Item payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= in_user_i;
      addr_q <= in_data_i[AddrW-1:0];
      syn_q  <= in_data_i[AddrW];
      ack_q  <= in_data_i[AddrW+1];
    end
    if (cmd_i.latch_cur) begin
      cur_addr_q <= src_addr_rd;
      cur_cnt_q  <= src_cnt_rd;
    end
    if (cmd_i.cand_update && (!found_q || cur_cnt_q > best_cnt_q)) begin
      best_addr_q <= cur_addr_q;
      best_cnt_q  <= cur_cnt_q;
    end
    if (cmd_i.out_load) begin
      out_user_q <= ev_q;
      out_data_q <= {6'd0, ovf_q, baddr_q, bvalid_q, total_q, syn_cnt_q};
    end
  end

  // Control state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sidx_q      <= '0;
      bidx_q      <= '0;
      src_used_q  <= '0;
      blk_used_q  <= '0;
      syn_cnt_q   <= '0;
      scan_q      <= 1'b0;
      ovf_q       <= 1'b0;
      acc_q       <= '0;
      found_q     <= 1'b0;
      choose_q    <= 1'b0;
      ev_q        <= EvQuiet;
      total_q     <= '0;
      bvalid_q    <= 1'b0;
      baddr_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.bidx_clr) bidx_q <= '0;
      else if (cmd_i.bidx_inc) bidx_q <= bidx_q + 1'b1;
      if (cmd_i.sidx_clr) sidx_q <= '0;
      else if (cmd_i.sidx_inc) sidx_q <= sidx_q + 1'b1;

      if (cmd_i.inc_syn && syn_cnt_q != CntMax) syn_cnt_q <= syn_cnt_q + 1'b1;

      // new source or dropped one
      if (cmd_i.src_new) begin
        if (src_full) ovf_q <= 1'b1;
        else src_used_q <= src_used_q + 1'b1;
      end
      if (blk_we) blk_used_q <= blk_used_q + 1'b1;

      if (cmd_i.cand_update && (!found_q || cur_cnt_q > best_cnt_q)) found_q <= 1'b1;

      // threshold rules at the tick
      if (cmd_i.tick_eval) begin
        found_q  <= 1'b0;
        bvalid_q <= 1'b0;
        baddr_q  <= '0;
        total_q  <= '0;
        choose_q <= 1'b0;
        ev_q     <= EvQuiet;
        if (scan_q) begin
          if (syn_cnt_q <= panic_i) begin
            scan_q  <= 1'b0;
            ev_q    <= EvScanOver;
            total_q <= acc_sat;
            acc_q   <= '0;
          end else begin
            acc_q    <= acc_sat;
            ev_q     <= EvScanCont;
            choose_q <= 1'b1;
          end
        end else if (syn_cnt_q > panic_i) begin
          scan_q   <= 1'b1;
          acc_q    <= acc_sat;
          ev_q     <= EvScanDet;
          choose_q <= 1'b1;
        end else if (syn_cnt_q > warn_i) begin
          ev_q <= EvWarning;
        end
      end

      if (cmd_i.tick_fin && block_now) begin
        bvalid_q <= 1'b1;
        baddr_q  <= best_addr_q;
      end

      // result register, interval store cleared on hand-off
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
        src_used_q  <= '0;
        syn_cnt_q   <= '0;
        ovf_q       <= 1'b0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

endmodule

// ----- rtl/syn_flood_heavy_hitter_blocker_top.sv -----
// ----------------------------------------------------------------------------
// syn_flood_heavy_hitter_blocker_top
// SYN flood detector with per-source counting and heavy-hitter blocking.
// ----------------------------------------------------------------------------
// Input stream: one word per item; tuser selects packet, interval tick or
// preload of a blocked address. Output stream: one word per tick only.
// Configuration: APB registers at 0x0 warning, 0x4 panic, 0x8 min block
// count (24 bits each), written only while the block is idle; the user is bound
// by this, and the block itself does not enforce it. One item is worked at a
// time; tready is high only when the sequencer idles. Packet: a non-SYN goes
// back to idle after dispatch; a SYN without ACK walks the blocked table (read,
// compare per entry) and, if not blocked, the source table (read, compare per
// entry). Preload: one blocked table walk. Tick: without selection it evaluates
// and loads the output; with selection each source entry is read, latched and
// followed by a blocked table walk, as each table has a single read port.
// Reset clears counters, scan state and the output valid; table contents are
// undefined and are never read beyond the fill counts.
// A stalled receiver holds the result word; other items keep flowing, but the
// next tick waits for the output register and holds off the input until then.
// ----------------------------------------------------------------------------
module syn_flood_heavy_hitter_blocker_top
  import sfhb_pkg::*;
#(
  parameter int unsigned SOURCE_ENTRIES  = SourceEntriesDef,
  parameter int unsigned BLOCKED_ENTRIES = BlockedEntriesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // source_ip, syn_flag, ack_flag
  input  logic [InUserW-1:0]  s_axis_tuser,   // func
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // interval_count, scan_total, block_valid, block_address, table_overflow
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic [OutUserW-1:0] m_axis_tuser,   // event_code
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [CntW-1:0] warn_q, panic_q, min_q;
  logic            cfg_we;
  cmd_t            cmd;
  sts_t            sts;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warn_q  <= WarnRst;
      panic_q <= PanicRst;
      min_q   <= MinRst;
    end else if (cfg_we) begin
      case (paddr[3:2])
        RegWarn:  warn_q  <= pwdata[CntW-1:0];
        RegPanic: panic_q <= pwdata[CntW-1:0];
        RegMin:   min_q   <= pwdata[CntW-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegWarn:  prdata = {8'd0, warn_q};
      RegPanic: prdata = {8'd0, panic_q};
      RegMin:   prdata = {8'd0, min_q};
      default:  prdata = '0;
    endcase
  end

  sfhb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sfhb_dp #(
    .SOURCE_ENTRIES  (SOURCE_ENTRIES),
    .BLOCKED_ENTRIES (BLOCKED_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .warn_i      (warn_q),
    .panic_i     (panic_q),
    .min_i       (min_q),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

// ----- bench/tb_syn_flood_heavy_hitter_blocker_top.sv -----
// ----------------------------------------------------------------------------
// tb_syn_flood_heavy_hitter_blocker_top
// Self-checking bench for the SYN flood heavy-hitter blocker. A behavioral
// predictor tracks source counts, the blocked table and scan state, and every
// tick report from the block is compared field by field with the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_syn_flood_heavy_hitter_blocker_top;
  import sfhb_pkg::*;

  localparam int unsigned NSrc = 64;
  localparam int unsigned NBlk = 64;
  localparam logic [23:0] Max24 = 24'hFFFFFF;
  localparam longint unsigned CycleLimit = 3000000;
  localparam logic [1:0] FuncUnused = 2'd3;

  typedef struct packed {
    logic [2:0]  event_code;
    logic [23:0] interval_count;
    logic [31:0] scan_total;
    logic        block_valid;
    logic [31:0] block_address;
    logic        table_overflow;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;  // source_ip, syn_flag, ack_flag
  logic [InUserW-1:0] s_axis_tuser = '0;  // func
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // interval_count, scan_total, block_valid, block_address, table_overflow
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;      // event_code
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  syn_flood_heavy_hitter_blocker_top uut (.*);

  // predictor state
  logic [23:0] warn_thr, panic_thr, min_cnt;
  logic [31:0] src_addr [NSrc];
  logic [23:0] src_cnt [NSrc];
  int unsigned src_used;
  logic [31:0] blk_tab [NBlk];
  int unsigned blk_used;
  logic [23:0] syn_cnt;
  logic        in_scan;
  logic [31:0] scan_acc;
  logic        ovf_seen;

  report_t expected_reports[$];
  int unsigned fail_cnt = 0;
  longint unsigned cycle_cnt = 0;
  bit hold_rx = 1'b0;
  int unsigned hold_cycles = 0;

  initial forever #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stall pattern, with a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_rx) begin
      hold_cycles <= 2000;
      hold_rx <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (cycle_cnt[7:5] == 3'd5) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    report_t got, exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tuser, m_axis_tdata[23:0], m_axis_tdata[55:24], m_axis_tdata[56],
              m_axis_tdata[88:57], m_axis_tdata[89]};
      if (expected_reports.size() == 0) begin
        $error("unexpected report word %h", m_axis_tdata);
        fail_cnt++;
      end else begin
        exp_r = expected_reports.pop_front();
        if (got.event_code !== exp_r.event_code) begin
          $error("event_code exp %0d got %0d", exp_r.event_code, got.event_code); fail_cnt++;
        end
        if (got.interval_count !== exp_r.interval_count) begin
          $error("interval_count exp %0d got %0d", exp_r.interval_count,
                 got.interval_count); fail_cnt++;
        end
        if (got.scan_total !== exp_r.scan_total) begin
          $error("scan_total exp %0d got %0d", exp_r.scan_total, got.scan_total); fail_cnt++;
        end
        if (got.block_valid !== exp_r.block_valid) begin
          $error("block_valid exp %0d got %0d", exp_r.block_valid, got.block_valid);
          fail_cnt++;
        end
        if (got.block_address !== exp_r.block_address) begin
          $error("block_address exp %h got %h", exp_r.block_address, got.block_address);
          fail_cnt++;
        end
        if (got.table_overflow !== exp_r.table_overflow) begin
          $error("table_overflow exp %0d got %0d", exp_r.table_overflow,
                 got.table_overflow); fail_cnt++;
        end
      end
    end
  end

  function automatic bit addr_blocked(logic [31:0] a);
    for (int i = 0; i < blk_used; i++) if (blk_tab[i] == a) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void block_addr(logic [31:0] a);
    if (blk_used < NBlk && !addr_blocked(a)) begin
      blk_tab[blk_used] = a;
      blk_used++;
    end
  endfunction

  function automatic logic [31:0] acc_sat(logic [31:0] a, logic [23:0] b);
    logic [32:0] s;
    s = a + b;
    return s[32] ? 32'hFFFFFFFF : s[31:0];
  endfunction

  // heaviest unblocked source, earliest wins ties
  function automatic bit pick_heavy(output logic [31:0] a);
    int best;
    logic [23:0] best_cnt;
    bit found;
    found = 0; best = 0; best_cnt = 0; a = '0;
    for (int i = 0; i < src_used; i++) begin
      if (addr_blocked(src_addr[i])) continue;
      if (!found || src_cnt[i] > best_cnt) begin
        found = 1; best = i; best_cnt = src_cnt[i];
      end
    end
    if (!found || best_cnt < min_cnt) return 1'b0;
    a = src_addr[best];
    block_addr(a);
    return 1'b1;
  endfunction

  function automatic void predict_item(logic [1:0] fn, logic [31:0] a, logic syn, logic ack);
    report_t r;
    bit hit;
    logic [23:0] n;
    if (fn == FuncPacket) begin
      if (syn && !ack) begin
        if (syn_cnt < Max24) syn_cnt++;
        if (!addr_blocked(a)) begin
          hit = 0;
          for (int i = 0; i < src_used; i++)
            if (!hit && src_addr[i] == a) begin
              hit = 1;
              if (src_cnt[i] < Max24) src_cnt[i]++;
            end
          if (!hit) begin
            if (src_used < NSrc) begin
              src_addr[src_used] = a; src_cnt[src_used] = 1; src_used++;
            end else ovf_seen = 1;
          end
        end
      end
    end else if (fn == FuncPreload) begin
      block_addr(a);
    end else if (fn == FuncTick) begin
      r = '0;
      n = syn_cnt;
      r.interval_count = n;
      if (in_scan) begin
        scan_acc = acc_sat(scan_acc, n);
        if (n <= panic_thr) begin
          in_scan = 0; r.event_code = EvScanOver; r.scan_total = scan_acc; scan_acc = 0;
        end else begin
          r.event_code = EvScanCont;
          r.block_valid = pick_heavy(r.block_address);
        end
      end else if (n > panic_thr) begin
        in_scan = 1; scan_acc = acc_sat(scan_acc, n);
        r.event_code = EvScanDet;
        r.block_valid = pick_heavy(r.block_address);
      end else if (n > warn_thr) begin
        r.event_code = EvWarning;
      end else begin
        r.event_code = EvQuiet;
      end
      r.table_overflow = ovf_seen;
      expected_reports = {expected_reports, r};
      src_used = 0; syn_cnt = 0; ovf_seen = 0;
    end
  endfunction

  // send one word, with random bursts and gaps
  int unsigned burst_left = 0;
  task automatic send_item(logic [1:0] fn, logic [31:0] a, logic syn, logic ack);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= fn;
    s_axis_tdata <= {6'd0, ack, syn, a};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_item(fn, a, syn, ack);
    // the block is busy after an accepted word
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic syn_pkt(logic [31:0] a);
    send_item(FuncPacket, a, 1'b1, 1'b0);
  endtask

  task automatic tick();
    send_item(FuncTick, $urandom, 1'($urandom), 1'($urandom));
  endtask

  task automatic drain();
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (20000) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] v);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00};
    pwdata <= {8'($urandom_range(0, 255)), v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegWarn:  warn_thr = v;
      RegPanic: panic_thr = v;
      default:  min_cnt = v;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_thresholds(logic [23:0] w, logic [23:0] p, logic [23:0] m);
    drain();
    write_reg(RegWarn, w);
    write_reg(RegPanic, p);
    write_reg(RegMin, m);
  endtask

  // quiet, warning, scan entry/continue/exit, ties, non-SYNs, unknown func
  task automatic test_directed();
    send_item(FuncPacket, 32'hFFFFFFFF, 1'b1, 1'b1);
    send_item(FuncPacket, 32'h0, 1'b0, 1'b0);
    send_item(FuncPacket, 32'h0, 1'b0, 1'b1);
    send_item(FuncUnused, 32'hFFFFFFFF, 1'b1, 1'b0);
    tick();
    set_thresholds(24'd1, 24'd3, 24'd2);
    syn_pkt(32'h0); syn_pkt(32'h0);
    tick();
    syn_pkt(32'hA); syn_pkt(32'hB); syn_pkt(32'hB); syn_pkt(32'hA);
    tick();
    syn_pkt(32'hB); syn_pkt(32'hFFFFFFFF); syn_pkt(32'hFFFFFFFF); syn_pkt(32'hC);
    tick();
    send_item(FuncPreload, 32'h5, 1'b0, 1'b0);
    send_item(FuncPreload, 32'h5, 1'b1, 1'b1);
    syn_pkt(32'h5);
    tick();
  endtask

  // new sources past table capacity
  task automatic test_source_overflow();
    set_thresholds(24'd0, 24'd0, 24'd1);
    for (int i = 0; i < NSrc + 4; i++) syn_pkt(32'h1000 + i);
    tick();
    tick();
  endtask

  // fill blocked table, then preload and block attempts while full
  task automatic test_blocked_full();
    for (int i = 0; i < NBlk + 2; i++) send_item(FuncPreload, 32'h9000_0000 + i, 1'b0, 1'b0);
    syn_pkt(32'h77); syn_pkt(32'h77);
    tick();
    syn_pkt(32'h77);
    tick();
  endtask

  // thresholds at zero with a preloaded blocked source, then at their maximum
  task automatic test_saturation();
    set_thresholds(24'd0, 24'd0, 24'd1);
    send_item(FuncPreload, 32'h42, 1'b0, 1'b0);
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) syn_pkt(32'h42);
      tick();
    end
    set_thresholds(Max24, Max24, Max24);
    tick();
  endtask

  // random traffic, mostly SYN bursts from a small source pool
  task automatic test_random(int unsigned items);
    int unsigned r;
    logic [31:0] pool [8];
    for (int i = 0; i < 8; i++) pool[i] = $urandom;
    for (int unsigned k = 0; k < items; k++) begin
      r = $urandom_range(0, 99);
      if (k == items / 2) hold_rx = 1'b1;
      if (r < 8) tick();
      else if (r < 10) send_item(FuncPreload, $urandom_range(0, 3) == 0 ? $urandom
                                 : pool[$urandom_range(0, 7)], 1'($urandom), 1'($urandom));
      else if (r < 12) send_item(FuncUnused, $urandom, 1'($urandom), 1'($urandom));
      else if (r < 80) syn_pkt(pool[$urandom_range(0, $urandom_range(0, 7))]);
      else send_item(FuncPacket, r < 90 ? $urandom : pool[$urandom_range(0, 7)],
                     1'($urandom), 1'($urandom));
    end
    tick();
  endtask

  initial begin
    warn_thr = WarnRst; panic_thr = PanicRst; min_cnt = MinRst;
    src_used = 0; blk_used = 0; syn_cnt = 0; in_scan = 0; scan_acc = 0; ovf_seen = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_source_overflow();
    test_blocked_full();
    test_saturation();
    set_thresholds(24'd6, 24'd12, 24'd3);
    test_random(260);
    set_thresholds(24'd2, 24'd5, 24'd1);
    test_random(260);
    drain();
    if (fail_cnt == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sfhb_pkg.sv
rtl/sfhb_ram.sv
rtl/sfhb_ctrl.sv
rtl/sfhb_dp.sv
rtl/syn_flood_heavy_hitter_blocker_top.sv
bench/tb_syn_flood_heavy_hitter_blocker_top.sv
